FILE: hdl/edf_pkg.sv
// Shared types and constants for the escaped frame deframer.
package edf_pkg;

    // Widths of counters and fields
    localparam int RAW_W   = 8;
    localparam int CNT_W   = 7;
    localparam int TICK_W  = 16;
    localparam int CFG_IDX_W = 2;

    // Frame limits
    localparam logic [RAW_W-1:0] RAW_LIMIT   = 8'd128;
    localparam logic [CNT_W-1:0] MAX_PAYLOAD = 7'd64;

    // Item commands
    localparam logic [1:0] CMD_START = 2'd0;
    localparam logic [1:0] CMD_BYTE  = 2'd1;
    localparam logic [1:0] CMD_TICK  = 2'd2;

    // Special link bytes
    localparam logic [7:0] BYTE_START = 8'hFE;
    localparam logic [7:0] BYTE_END   = 8'hFF;
    localparam logic [7:0] BYTE_ESC   = 8'hFD;
    localparam logic [7:0] ESC_MAX    = 8'h02;

    // Final status codes
    localparam logic [3:0] ST_OK         = 4'd0;
    localparam logic [3:0] ST_NORESP     = 4'd1;
    localparam logic [3:0] ST_NOSTART    = 4'd2;
    localparam logic [3:0] ST_INCOMPLETE = 4'd3;
    localparam logic [3:0] ST_TOOSHORT   = 4'd4;
    localparam logic [3:0] ST_EMPTY      = 4'd5;
    localparam logic [3:0] ST_BADESC     = 4'd6;
    localparam logic [3:0] ST_OVERFLOW   = 4'd7;
    localparam logic [3:0] ST_SHORT      = 4'd8;

    // Configuration register indexes and reset values
    localparam logic [CFG_IDX_W-1:0] CFG_OVERALL_TIMEOUT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDLE_TIMEOUT    = 2'd1;
    localparam logic [TICK_W-1:0] OVERALL_TIMEOUT_RST = 16'd1000;
    localparam logic [TICK_W-1:0] IDLE_TIMEOUT_RST    = 16'd100;

    typedef struct packed {
        logic [1:0]       command;
        logic [7:0]       rx_byte;
        logic [CNT_W-1:0] expected_length;
    } item_t;

    typedef struct packed {
        logic             is_final;
        logic [7:0]       data_byte;
        logic [CNT_W-1:0] byte_index;
        logic [3:0]       status;
    } result_t;

    typedef struct packed {
        logic [TICK_W-1:0] overall_timeout_ticks;
        logic [TICK_W-1:0] idle_timeout_ticks;
    } cfg_t;

endpackage

FILE: hdl/edf_if.sv
// Channel interfaces: input items, result items and configuration writes.
interface edf_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] command;
    logic [7:0] rx_byte;
    logic [6:0] expected_length;

    modport source (output valid, command, rx_byte, expected_length, input ready);
    modport sink   (input valid, command, rx_byte, expected_length, output ready);
endinterface

interface edf_rsp_if;
    logic       valid;
    logic       ready;
    logic       is_final;
    logic [7:0] data_byte;
    logic [6:0] byte_index;
    logic [3:0] status;

    modport source (output valid, is_final, data_byte, byte_index, status, input ready);
    modport sink   (input valid, is_final, data_byte, byte_index, status, output ready);
endinterface

interface edf_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [15:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: hdl/edf_core.sv
// Deframer state machine: hunts for the start mark, unescapes payload, reports status.
module edf_core (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  edf_pkg::item_t   item,
    input  edf_pkg::cfg_t    cfg,
    output logic             res_valid,
    output edf_pkg::result_t res
);
    import edf_pkg::*;

    localparam logic [2:0] PH_IDLE = 3'd0;
    localparam logic [2:0] PH_HUNT = 3'd1;
    localparam logic [2:0] PH_ADDR = 3'd2;
    localparam logic [2:0] PH_DATA = 3'd3;
    localparam logic [2:0] PH_ESC  = 3'd4;

    logic [2:0]        phase_reg, phase_next;
    logic [TICK_W-1:0] elapsed_reg, elapsed_next;
    logic [TICK_W-1:0] idle_reg, idle_next;
    logic [RAW_W-1:0]  raw_reg, raw_next;
    logic [CNT_W-1:0]  decoded_reg, decoded_next;
    logic [CNT_W-1:0]  wanted_reg, wanted_next;
    logic [3:0]        error_reg, error_next;

    logic              fin;
    logic [3:0]        fin_status;
    logic              emit;
    logic [7:0]        emit_byte;
    logic [RAW_W-1:0]  raw_inc;
    logic [TICK_W-1:0] elapsed_inc;
    logic [TICK_W-1:0] idle_inc;
    logic [3:0]        end_error;

    assign raw_inc     = raw_reg + RAW_W'(1);
    assign elapsed_inc = (elapsed_reg == '1) ? elapsed_reg : elapsed_reg + TICK_W'(1);
    assign idle_inc    = (idle_reg == '1) ? idle_reg : idle_reg + TICK_W'(1);
    // bad escape right before the end mark counts only if no earlier error
    assign end_error   = (phase_reg == PH_ESC && error_reg == ST_OK) ? ST_BADESC : error_reg;

    // Next state and result for one item
    always_comb
    begin
        phase_next   = phase_reg;
        elapsed_next = elapsed_reg;
        idle_next    = idle_reg;
        raw_next     = raw_reg;
        decoded_next = decoded_reg;
        wanted_next  = wanted_reg;
        error_next   = error_reg;
        fin          = 1'b0;
        fin_status   = ST_OK;
        emit         = 1'b0;
        emit_byte    = item.rx_byte;
        res_valid    = 1'b0;
        res          = '0;

        if (step) begin
            if (item.command == CMD_START) begin
                wanted_next  = (item.expected_length > MAX_PAYLOAD) ? MAX_PAYLOAD
                                                                    : item.expected_length;
                phase_next   = PH_HUNT;
                elapsed_next = '0;
                idle_next    = '0;
                raw_next     = '0;
                decoded_next = '0;
                error_next   = ST_OK;
            end
            else if (phase_reg != PH_IDLE) begin
                case (item.command)
                    CMD_BYTE:
                    begin
                        idle_next = '0;
                        if (phase_reg == PH_HUNT) begin
                            if (item.rx_byte == BYTE_START) begin
                                raw_next   = RAW_W'(1);
                                phase_next = PH_ADDR;
                            end
                        end
                        else begin
                            raw_next = raw_inc;
                            if (phase_reg == PH_ADDR) begin
                                if (item.rx_byte == BYTE_END) begin
                                    fin        = 1'b1;
                                    fin_status = ST_TOOSHORT;
                                end
                                else begin
                                    phase_next = PH_DATA;
                                end
                            end
                            else if (item.rx_byte == BYTE_END) begin
                                error_next = end_error;
                                fin        = 1'b1;
                                if (end_error != ST_OK)
                                    fin_status = end_error;
                                else if (decoded_reg == '0)
                                    fin_status = ST_EMPTY;
                                else if (decoded_reg != wanted_reg)
                                    fin_status = ST_SHORT;
                                else
                                    fin_status = ST_OK;
                            end
                            else if (raw_inc >= RAW_LIMIT) begin
                                fin        = 1'b1;
                                fin_status = ST_INCOMPLETE;
                            end
                            else if (phase_reg == PH_ESC) begin
                                phase_next = PH_DATA;
                                if (error_reg == ST_OK) begin
                                    if (decoded_reg >= wanted_reg)
                                        error_next = ST_OVERFLOW;
                                    else if (item.rx_byte > ESC_MAX)
                                        error_next = ST_BADESC;
                                    else begin
                                        emit      = 1'b1;
                                        emit_byte = BYTE_ESC + item.rx_byte;
                                    end
                                end
                            end
                            else if (item.rx_byte == BYTE_ESC) begin
                                phase_next = PH_ESC;
                            end
                            else if (error_reg == ST_OK) begin
                                if (decoded_reg >= wanted_reg)
                                    error_next = ST_OVERFLOW;
                                else
                                    emit = 1'b1;
                            end
                        end
                    end
                    CMD_TICK:
                    begin
                        elapsed_next = elapsed_inc;
                        if (elapsed_inc >= cfg.overall_timeout_ticks) begin
                            fin = 1'b1;
                            if (phase_reg == PH_HUNT)
                                fin_status = ST_NOSTART;
                            else if (phase_reg == PH_ADDR)
                                fin_status = ST_TOOSHORT;
                            else
                                fin_status = ST_INCOMPLETE;
                        end
                        else begin
                            idle_next = idle_inc;
                            if (phase_reg == PH_HUNT && idle_inc > cfg.idle_timeout_ticks) begin
                                fin        = 1'b1;
                                fin_status = ST_NORESP;
                            end
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
        end

        // Build the result item
        if (fin) begin
            phase_next     = PH_IDLE;
            res_valid      = 1'b1;
            res.is_final   = 1'b1;
            res.byte_index = decoded_reg;
            res.status     = fin_status;
        end
        else if (emit) begin
            res_valid      = 1'b1;
            res.data_byte  = emit_byte;
            res.byte_index = decoded_reg;
            decoded_next   = decoded_reg + CNT_W'(1);
        end
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg   <= PH_IDLE;
            elapsed_reg <= '0;
            idle_reg    <= '0;
            raw_reg     <= '0;
            decoded_reg <= '0;
            wanted_reg  <= '0;
            error_reg   <= ST_OK;
        end
        else begin
            phase_reg   <= phase_next;
            elapsed_reg <= elapsed_next;
            idle_reg    <= idle_next;
            raw_reg     <= raw_next;
            decoded_reg <= decoded_next;
            wanted_reg  <= wanted_next;
            error_reg   <= error_next;
        end
    end

`ifndef ASSERT_OFF
    a_decoded_bound: assert property (@(posedge clk) disable iff (!rst_n)
        decoded_reg <= wanted_reg)
        else $error("decoded count passed wanted length");

    a_raw_bound: assert property (@(posedge clk) disable iff (!rst_n)
        raw_reg <= RAW_LIMIT)
        else $error("raw count passed raw limit");

    a_final_idles: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.is_final |=> phase_reg == PH_IDLE)
        else $error("final status did not end reception");

    a_data_in_payload: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res.is_final |-> phase_reg == PH_DATA || phase_reg == PH_ESC)
        else $error("data item outside payload");
`endif

endmodule

FILE: hdl/escaped_frame_deframer_unit.sv
// Each accepted item passes through the input register; its result, if any, is presented from the result register.
// Throughput: one item per cycle while results are taken; the state machine decides one item per cycle.
// An item waits in the input register while a result is pending and not taken, whether or not
// it makes a result of its own, so input ready follows result ready in the same cycle.
// Reset (rst_n, async, active low): idle phase, counters cleared, timeouts 1000 and 100.
// The configuration channel is always ready.
module escaped_frame_deframer_unit (
    input  logic      clk,
    input  logic      rst_n,
    edf_req_if.sink   req,
    edf_rsp_if.source rsp,
    edf_cfg_if.sink   cfg
);
    import edf_pkg::*;

    logic    stage_valid_reg;
    item_t   stage_item_reg;
    logic    rsp_valid_reg;
    result_t rsp_reg;
    cfg_t    cfg_reg;

    logic    consume;
    logic    res_valid;
    result_t res;

    // Input register moves on when the result register can take its result
    assign consume   = stage_valid_reg && (!rsp_valid_reg || rsp.ready);
    assign req.ready = !stage_valid_reg || consume;
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else if (req.ready)
        begin
            stage_valid_reg <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            stage_item_reg.command         <= req.command;
            stage_item_reg.rx_byte         <= req.rx_byte;
            stage_item_reg.expected_length <= req.expected_length;
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.overall_timeout_ticks <= OVERALL_TIMEOUT_RST;
            cfg_reg.idle_timeout_ticks    <= IDLE_TIMEOUT_RST;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_OVERALL_TIMEOUT: cfg_reg.overall_timeout_ticks <= cfg.data;
                CFG_IDLE_TIMEOUT:    cfg_reg.idle_timeout_ticks    <= cfg.data;
                default:
                begin
                end
            endcase
        end
    end

    edf_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (consume),
        .item      (stage_item_reg),
        .cfg       (cfg_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (consume && res_valid)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (consume && res_valid)
        begin
            rsp_reg <= res;
        end
    end

    assign rsp.valid     = rsp_valid_reg;
    assign rsp.is_final  = rsp_reg.is_final;
    assign rsp.data_byte = rsp_reg.data_byte;
    assign rsp.byte_index = rsp_reg.byte_index;
    assign rsp.status    = rsp_reg.status;

`ifndef ASSERT_OFF
    a_stage_held: assert property (@(posedge clk) disable iff (!rst_n)
        stage_valid_reg && !consume |=> stage_valid_reg)
        else $error("stalled input item dropped");

    a_no_result_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && !rsp.ready |-> !consume)
        else $error("pending result overwritten");

    a_result_from_item: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(consume))
        else $error("result without a processed item");
`endif

endmodule
